/* rtl/ppr_pkg.sv */
package ppr_pkg;

  localparam int TILES      = 16;
  localparam int TILE_W     = 4;
  localparam int BOARD_W    = 64;
  localparam int CODE_W     = 3;
  localparam int MAP_W      = 48;
  localparam int RANK_W     = 45;
  localparam int NCELL_W    = 5;
  localparam int GCNT_W     = 3;
  localparam int GIDX_W     = 2;
  localparam int REG_IDX_W  = 2;
  localparam int QUADS      = TILES / 4;
  localparam int CELLS_MIN  = 4;
  localparam int CELLS_DEF  = 16;
  localparam int GROUPS_DEF = 4;

  localparam logic [MAP_W-1:0]   MAP_RESET    = '1;
  localparam logic [NCELL_W-1:0] NCELL_RESET  = NCELL_W'(16);
  localparam logic [GCNT_W-1:0]  GCOUNT_RESET = GCNT_W'(1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TILE_GROUP_MAP = 2'd0,
    REG_CELLS_IN_USE   = 2'd1,
    REG_GROUP_COUNT    = 2'd2
  } reg_idx_t;

  typedef logic [TILE_W-1:0] tile_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    logic               found;
    tile_t              first;
    tile_t              lastc;
    logic [CODE_W-1:0]  code;
    logic               member;
  } tile_info_t;

  typedef struct packed {
    tile_t              digit;
    tile_t              pos;
    logic [CODE_W-1:0]  code;
    logic               member;
  } tile_digit_t;

  // Entry a*TILES+b holds the falling factorial a*(a-1)*...*(a-b+1).
  function automatic logic [TILES*TILES-1:0][RANK_W-1:0] fall_table();
    logic [TILES*TILES-1:0][RANK_W-1:0] tab;
    logic [RANK_W-1:0] acc;
    tab = '0;
    for (int a = 0; a < TILES; a++) begin
      acc = RANK_W'(1);
      for (int b = 0; b < TILES; b++) begin
        tab[a*TILES+b] = acc;
        if (b < a) begin
          acc = RANK_W'(acc * RANK_W'(a - b));
        end else begin
          acc = '0;
        end
      end
    end
    return tab;
  endfunction

  localparam logic [TILES*TILES-1:0][RANK_W-1:0] FALL_TAB = fall_table();

endpackage

/* rtl/ppr_scan.sv */
module ppr_scan import ppr_pkg::*; #(
  parameter int CELLS = CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [BOARD_W-1:0]  board,
  input  logic [MAP_W-1:0]    group_map,
  input  logic [NCELL_W-1:0]  ncells,
  input  logic [GCNT_W-1:0]   gcount,
  output logic                out_valid,
  output tile_info_t          info [TILES],
  output logic [NCELL_W-1:0]  out_ncells,
  output logic [GCNT_W-1:0]   out_gcount
);

  logic [CELLS-1:0] hit [TILES];
  tile_info_t       info_next [TILES];

  always_comb begin
    for (int t = 0; t < TILES; t++) begin
      for (int c = 0; c < CELLS; c++) begin
        hit[t][c] = (NCELL_W'(c) < ncells) && (board[TILE_W*c +: TILE_W] == TILE_W'(t));
      end
    end
  end

  always_comb begin
    for (int t = 0; t < TILES; t++) begin
      info_next[t].found = |hit[t];
      info_next[t].first = '0;
      info_next[t].lastc = '0;
      for (int c = CELLS - 1; c >= 0; c--) begin
        if (hit[t][c]) begin
          info_next[t].first = TILE_W'(c);
        end
      end
      for (int c = 0; c < CELLS; c++) begin
        if (hit[t][c]) begin
          info_next[t].lastc = TILE_W'(c);
        end
      end
      info_next[t].code = group_map[CODE_W*t +: CODE_W];
      // Codes with the top bit set mean the tile is in no group.
      info_next[t].member = (t != 0) && (NCELL_W'(t) < ncells) &&
                            !group_map[CODE_W*t + CODE_W - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    info       <= info_next;
    out_ncells <= ncells;
    out_gcount <= gcount;
  end

endmodule

/* rtl/ppr_digit.sv */
module ppr_digit import ppr_pkg::*; #(
  parameter int GROUPS = GROUPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  tile_info_t          info [TILES],
  input  logic [NCELL_W-1:0]  ncells,
  input  logic [GCNT_W-1:0]   gcount,
  output logic                out_valid,
  output tile_digit_t         digits [TILES],
  output tile_t               mcount [GROUPS],
  output logic [NCELL_W-1:0]  out_ncells,
  output logic [GCNT_W-1:0]   out_gcount
);

  tile_digit_t digits_next [TILES];
  tile_t       mcount_next [GROUPS];

  always_comb begin
    tile_t below;
    tile_t pos;
    logic  same;
    for (int t = 0; t < TILES; t++) begin
      below = '0;
      pos   = '0;
      for (int u = 0; u < TILES; u++) begin
        same = (u < t) && info[u].member && (info[u].code == info[t].code);
        if (same) begin
          pos = pos + TILE_W'(1);
        end
        if (same && info[u].found && (info[u].first < info[t].lastc)) begin
          below = below + TILE_W'(1);
        end
      end
      digits_next[t].digit  = info[t].found ? (info[t].lastc - below) : '0;
      digits_next[t].pos    = pos;
      digits_next[t].code   = info[t].code;
      digits_next[t].member = info[t].member;
    end
  end

  always_comb begin
    tile_t cnt;
    for (int g = 0; g < GROUPS; g++) begin
      cnt = '0;
      for (int t = 0; t < TILES; t++) begin
        if (info[t].member && (info[t].code == CODE_W'(g))) begin
          cnt = cnt + TILE_W'(1);
        end
      end
      mcount_next[g] = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    digits     <= digits_next;
    mcount     <= mcount_next;
    out_ncells <= ncells;
    out_gcount <= gcount;
  end

endmodule

/* rtl/ppr_accum.sv */
module ppr_accum import ppr_pkg::*; #(
  parameter int GROUPS = GROUPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  tile_digit_t         digits [TILES],
  input  tile_t               mcount [GROUPS],
  input  logic [NCELL_W-1:0]  ncells,
  input  logic [GCNT_W-1:0]   gcount,
  output logic                out_valid,
  output rank_t               ranks [GROUPS],
  output logic [GCNT_W-1:0]   out_gcount
);

  rank_t             prod_next [TILES];
  logic [GROUPS-1:0] sel_next  [TILES];
  rank_t             prod      [TILES];
  logic [GROUPS-1:0] sel       [TILES];
  logic              p_valid;
  logic [GCNT_W-1:0] p_gcount;

  rank_t             qsum_next [GROUPS][QUADS];
  rank_t             qsum      [GROUPS][QUADS];
  logic              q_valid;
  logic [GCNT_W-1:0] q_gcount;

  rank_t             ranks_next [GROUPS];

  // Each digit is weighted by the falling factorial of the radices that follow it.
  always_comb begin
    tile_t m;
    tile_t a;
    tile_t b;
    rank_t w;
    for (int t = 0; t < TILES; t++) begin
      m = '0;
      for (int g = 0; g < GROUPS; g++) begin
        sel_next[t][g] = digits[t].member && (digits[t].code == CODE_W'(g));
        if (digits[t].code == CODE_W'(g)) begin
          m = mcount[g];
        end
      end
      a = TILE_W'(ncells - NCELL_W'(1) - NCELL_W'(digits[t].pos));
      b = m - TILE_W'(1) - digits[t].pos;
      w = FALL_TAB[{a, b}];
      prod_next[t] = RANK_W'(w * digits[t].digit);
    end
  end

  always_comb begin
    rank_t acc;
    for (int g = 0; g < GROUPS; g++) begin
      for (int q = 0; q < QUADS; q++) begin
        acc = '0;
        for (int i = 0; i < 4; i++) begin
          if (sel[4*q+i][g]) begin
            acc = acc + prod[4*q+i];
          end
        end
        qsum_next[g][q] = acc;
      end
    end
  end

  always_comb begin
    rank_t acc;
    for (int g = 0; g < GROUPS; g++) begin
      acc = '0;
      for (int q = 0; q < QUADS; q++) begin
        acc = acc + qsum[g][q];
      end
      ranks_next[g] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid   <= in_valid;
      q_valid   <= p_valid;
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod       <= prod_next;
    sel        <= sel_next;
    p_gcount   <= gcount;
    qsum       <= qsum_next;
    q_gcount   <= p_gcount;
    ranks      <= ranks_next;
    out_gcount <= q_gcount;
  end

endmodule

/* rtl/ppr_emit.sv */
module ppr_emit import ppr_pkg::*; #(
  parameter int GROUPS = GROUPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  rank_t              ranks [GROUPS],
  input  logic [GCNT_W-1:0]  gcount,
  output logic               strobe,
  output logic [GIDX_W-1:0]  group_index,
  output rank_t              rank,
  output logic               last
);

  logic [GCNT_W-1:0] left;
  rank_t             hold [GROUPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      left   <= '0;
    end else if (in_valid) begin
      strobe <= 1'b1;
      left   <= gcount - GCNT_W'(1);
    end else if (left != '0) begin
      strobe <= 1'b1;
      left   <= left - GCNT_W'(1);
    end else begin
      strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      group_index <= '0;
      rank        <= ranks[0];
      last        <= (gcount == GCNT_W'(1));
      for (int i = 0; i < GROUPS - 1; i++) begin
        hold[i] <= ranks[i+1];
      end
      hold[GROUPS-1] <= '0;
    end else if (left != '0) begin
      group_index <= group_index + GIDX_W'(1);
      rank        <= hold[0];
      last        <= (left == GCNT_W'(1));
      for (int i = 0; i < GROUPS - 1; i++) begin
        hold[i] <= hold[i+1];
      end
      hold[GROUPS-1] <= '0;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> left == '0)
    else $error("A new board reached the output while results were still pending.");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && group_index == $past(group_index) + GIDX_W'(1))
    else $error("The results of one board were not emitted in consecutive group order.");

endmodule

/* rtl/partial_permutation_ranker.sv */
// Ranks the tile placement of each tile group on a sliding-tile puzzle board.
// Configuration is written through wr_en, wr_index and wr_data while the block
// is idle: index 0 is the tile-to-group map, 1 the cell count, 2 the number of
// groups. A board is accepted at a rising edge where start is high and busy is
// low. For each group, in ascending order, one result appears on group_index,
// rank and last for a single cycle, marked by strobe; last flags the final group.
// The result for group 0 appears once the board has passed through the pipeline
// and the others follow in consecutive cycles. After each transaction busy stays
// high long enough that the results of successive boards do not overlap at the
// output; with a single group it never rises, so one board per cycle is taken.
// The pipeline runs scan, digit, product, partial sum, final
// sum and output register stages and never stalls, since the receiver must take
// each result as it appears. Reset clears the pipeline and restores the register
// defaults: every tile in no group, sixteen cells and a single group.
module partial_permutation_ranker import ppr_pkg::*; #(
  parameter int CELLS  = CELLS_DEF,
  parameter int GROUPS = GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [BOARD_W-1:0]    board,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [MAP_W-1:0]      wr_data,
  output logic                  strobe,
  output logic [GIDX_W-1:0]     group_index,
  output logic [RANK_W-1:0]     rank,
  output logic                  last
);

  logic [MAP_W-1:0]   tile_group_map;
  logic [NCELL_W-1:0] cells_in_use;
  logic [GCNT_W-1:0]  group_count;

  logic [NCELL_W-1:0] ncells_eff;
  logic [GCNT_W-1:0]  gcount_eff;
  logic [GCNT_W-1:0]  gap;
  logic               accept;

  logic               s1_valid;
  tile_info_t         s1_info [TILES];
  logic [NCELL_W-1:0] s1_ncells;
  logic [GCNT_W-1:0]  s1_gcount;

  logic               s2_valid;
  tile_digit_t        s2_digits [TILES];
  tile_t              s2_mcount [GROUPS];
  logic [NCELL_W-1:0] s2_ncells;
  logic [GCNT_W-1:0]  s2_gcount;

  logic               s3_valid;
  rank_t              s3_ranks [GROUPS];
  logic [GCNT_W-1:0]  s3_gcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_group_map <= MAP_RESET;
      cells_in_use   <= NCELL_RESET;
      group_count    <= GCOUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_TILE_GROUP_MAP: tile_group_map <= wr_data;
        REG_CELLS_IN_USE:   cells_in_use   <= wr_data[NCELL_W-1:0];
        REG_GROUP_COUNT:    group_count    <= wr_data[GCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cells_in_use < NCELL_W'(CELLS_MIN)) begin
      ncells_eff = NCELL_W'(CELLS_MIN);
    end else if (cells_in_use > NCELL_W'(CELLS)) begin
      ncells_eff = NCELL_W'(CELLS);
    end else begin
      ncells_eff = cells_in_use;
    end
    priority if (group_count == '0) begin
      gcount_eff = GCNT_W'(1);
    end else if (group_count > GCNT_W'(GROUPS)) begin
      gcount_eff = GCNT_W'(GROUPS);
    end else begin
      gcount_eff = group_count;
    end
  end

  assign busy   = (gap != '0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (accept) begin
      gap <= gcount_eff - GCNT_W'(1);
    end else if (gap != '0) begin
      gap <= gap - GCNT_W'(1);
    end
  end

  ppr_scan #(
    .CELLS (CELLS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .board      (board),
    .group_map  (tile_group_map),
    .ncells     (ncells_eff),
    .gcount     (gcount_eff),
    .out_valid  (s1_valid),
    .info       (s1_info),
    .out_ncells (s1_ncells),
    .out_gcount (s1_gcount)
  );

  ppr_digit #(
    .GROUPS (GROUPS)
  ) u_digit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .info       (s1_info),
    .ncells     (s1_ncells),
    .gcount     (s1_gcount),
    .out_valid  (s2_valid),
    .digits     (s2_digits),
    .mcount     (s2_mcount),
    .out_ncells (s2_ncells),
    .out_gcount (s2_gcount)
  );

  ppr_accum #(
    .GROUPS (GROUPS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .digits     (s2_digits),
    .mcount     (s2_mcount),
    .ncells     (s2_ncells),
    .gcount     (s2_gcount),
    .out_valid  (s3_valid),
    .ranks      (s3_ranks),
    .out_gcount (s3_gcount)
  );

  ppr_emit #(
    .GROUPS (GROUPS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s3_valid),
    .ranks       (s3_ranks),
    .gcount      (s3_gcount),
    .strobe      (strobe),
    .group_index (group_index),
    .rank        (rank),
    .last        (last)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 (strobe && group_index == '0))
    else $error("The first result of a transaction did not appear after the pipeline latency.");

endmodule
